// File: rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; imported by every module of the block.
package u16u8_pkg;

    localparam int CAP_W       = 9;
    localparam int UNITS_W     = 6;
    localparam int MAX_RESULTS = 5;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [8:0]  CAP_RESET   = 9'd64;
    localparam logic [5:0]  UNITS_RESET = 6'd31;

    localparam logic [15:0] HI_FIRST  = 16'hD800;
    localparam logic [15:0] HI_LAST   = 16'hDBFF;
    localparam logic [15:0] LO_FIRST  = 16'hDC00;
    localparam logic [15:0] LO_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] CTRL_END  = 21'h20;
    localparam logic [20:0] DEL_CHAR  = 21'h7F;
    localparam logic [20:0] QMARK_CP  = 21'h3F;
    localparam logic [7:0]  QMARK     = 8'h3F;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_NO_BYTES = 2'd2;

    localparam logic [0:0] REG_OUT_CAPACITY = 1'b0;
    localparam logic [0:0] REG_MAX_UNITS    = 1'b1;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [15:0] string_length;
        logic        last_unit;
    } t_unit_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic [1:0] status;
    } t_result_item;

    typedef struct packed {
        logic [2:0]       len;
        logic [3:0][7:0]  bytes;
    } t_seq;

    typedef struct packed {
        logic [2:0]                          count;
        t_result_item [MAX_RESULTS-1:0]      items;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_q_head;

    function automatic t_seq encode_point(input logic [20:0] cp);
        t_seq s;
        s.bytes = '0;
        if (cp < 21'h80) begin
            s.len      = 3'd1;
            s.bytes[0] = (cp < CTRL_END || cp == DEL_CHAR) ? QMARK : cp[7:0];
        end else if (cp < 21'h800) begin
            s.len      = 3'd2;
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < SUPP_BASE) begin
            s.len      = 3'd3;
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            s.len      = 3'd4;
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

endpackage

// File: rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level: APB registers, front end, queue, serializer.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
// One UTF-16 code unit is taken per cycle while full is low; each unit turns
// into zero to five results (UTF-8 bytes and, on the last unit, a zero
// terminator with status) that leave one per cycle through the pop side
// while pop is high, so results set the sustained rate. The front end
// decides each unit's bytes combinationally and parks them as a bundle in a
// four-entry queue; the byte serializer behind it loads the bundle and sets
// the output rate. Registers: out_capacity at 0x0, max_units at 0x4; write
// them only while the block is idle.
module utf16_to_utf8_transcoder_unit #(
    parameter int MAX_UNITS_LIMIT = 63,
    parameter int CAPACITY_LIMIT  = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  u16u8_pkg::t_unit_item   i_unit,
    input  logic                    pop,
    output logic                    empty,
    output u16u8_pkg::t_result_item o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import u16u8_pkg::*;

    logic [CAP_W-1:0]   r_out_capacity;
    logic [UNITS_W-1:0] r_max_units;
    logic               cfg_wr, accept, q_wr, q_rd;
    t_bundle            bundle;
    t_q_head            head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
            r_max_units    <= UNITS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2:2])
                REG_OUT_CAPACITY: r_out_capacity <= pwdata[CAP_W-1:0];
                REG_MAX_UNITS:    r_max_units    <= pwdata[UNITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2:2])
            REG_OUT_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, r_out_capacity};
            REG_MAX_UNITS:    prdata = {{(32-UNITS_W){1'b0}}, r_max_units};
            default:          prdata = '0;
        endcase
    end

    assign accept = push && !full;

    u16u8_front #(
        .MAX_UNITS_LIMIT (MAX_UNITS_LIMIT),
        .CAPACITY_LIMIT  (CAPACITY_LIMIT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_unit         (i_unit),
        .i_out_capacity (r_out_capacity),
        .i_max_units    (r_max_units),
        .o_wr           (q_wr),
        .o_bundle       (bundle)
    );

    u16u8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_bundle (bundle),
        .i_rd     (q_rd),
        .o_full   (full),
        .o_head   (head)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_rd     (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

// File: rtl/u16u8_front.sv
// Front end: accepts code units, tracks per-string state, builds result bundles.
// Depends on u16u8_pkg.
module u16u8_front #(
    parameter int MAX_UNITS_LIMIT = 63,
    parameter int CAPACITY_LIMIT  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  u16u8_pkg::t_unit_item      i_unit,
    input  logic [u16u8_pkg::CAP_W-1:0]   i_out_capacity,
    input  logic [u16u8_pkg::UNITS_W-1:0] i_max_units,
    output logic                       o_wr,
    output u16u8_pkg::t_bundle         o_bundle
);
    import u16u8_pkg::*;

    localparam int CAP_MAXV   = (1 << CAP_W) - 1;
    localparam int UNITS_MAXV = (1 << UNITS_W) - 1;
    localparam logic [CAP_W-1:0] CAP_CLAMP =
        (CAPACITY_LIMIT > CAP_MAXV) ? CAP_W'(CAP_MAXV) : CAP_W'(CAPACITY_LIMIT);
    localparam logic [UNITS_W-1:0] UNITS_CLAMP =
        (MAX_UNITS_LIMIT > UNITS_MAXV) ? UNITS_W'(UNITS_MAXV) : UNITS_W'(MAX_UNITS_LIMIT);

    logic [15:0]      r_pend_hi,  n_pend_hi;
    logic             r_pend_vld, n_pend_vld;
    logic [CAP_W-1:0] r_bw,       n_bw;
    logic             r_start,    n_start;
    logic             r_rej,      n_rej;
    logic             r_stop,     n_stop;

    logic [CAP_W-1:0]   cap;
    logic [UNITS_W-1:0] lim;
    logic               rej, active, is_hi, is_lo, pair, hold;
    logic               do1, do2, stop1, stop2;
    t_seq               seq1, seq2;
    logic [CAP_W:0]     sum1, sum2;
    logic [CAP_W-1:0]   bw1, bw2;
    logic [2:0]         n1, n2, rel;
    logic [20:0]        pair_cp;
    logic [1:0]         st;
    t_bundle            bundle;

    always_comb begin
        cap = (i_out_capacity > CAP_CLAMP) ? CAP_CLAMP : i_out_capacity;
        lim = (i_max_units > UNITS_CLAMP) ? UNITS_CLAMP : i_max_units;
        rej = r_start ? (i_unit.string_length == 16'd0 ||
                         i_unit.string_length > {{(16-UNITS_W){1'b0}}, lim}) : r_rej;
        active = !rej && !r_stop;
        is_hi  = i_unit.code_unit >= HI_FIRST && i_unit.code_unit <= HI_LAST;
        is_lo  = i_unit.code_unit >= LO_FIRST && i_unit.code_unit <= LO_LAST;
        pair   = r_pend_vld && is_lo;
        pair_cp = SUPP_BASE + 21'({r_pend_hi[9:0], i_unit.code_unit[9:0]});

        seq1  = encode_point(pair ? pair_cp : QMARK_CP);
        do1   = active && r_pend_vld;
        sum1  = {1'b0, r_bw} + {{(CAP_W-2){1'b0}}, seq1.len};
        stop1 = do1 && (sum1 >= {1'b0, cap});
        n1    = (do1 && !stop1) ? seq1.len : 3'd0;
        bw1   = (do1 && !stop1) ? sum1[CAP_W-1:0] : r_bw;

        hold  = active && !pair && !stop1 && is_hi && !i_unit.last_unit;
        seq2  = encode_point(is_lo ? QMARK_CP : {5'd0, i_unit.code_unit});
        do2   = active && !pair && !stop1 && !hold;
        sum2  = {1'b0, bw1} + {{(CAP_W-2){1'b0}}, seq2.len};
        stop2 = do2 && (sum2 >= {1'b0, cap});
        n2    = (do2 && !stop2) ? seq2.len : 3'd0;
        bw2   = (do2 && !stop2) ? sum2[CAP_W-1:0] : bw1;

        if (rej) begin
            st = ST_REJECTED;
        end else if (bw2 == '0) begin
            st = ST_NO_BYTES;
        end else begin
            st = ST_OK;
        end

        bundle.count = n1 + n2 + {2'd0, i_unit.last_unit};
        for (int k = 0; k < MAX_RESULTS; k++) begin
            rel = 3'(k) - n1;
            bundle.items[k].end_of_string = 1'b0;
            bundle.items[k].status        = ST_OK;
            if (3'(k) < n1) begin
                bundle.items[k].out_byte = seq1.bytes[k[1:0]];
            end else if (rel < n2) begin
                bundle.items[k].out_byte = seq2.bytes[rel[1:0]];
            end else begin
                bundle.items[k].out_byte      = 8'd0;
                bundle.items[k].end_of_string = 1'b1;
                bundle.items[k].status        = st;
            end
        end
    end

    always_comb begin
        n_pend_hi  = r_pend_hi;
        n_pend_vld = r_pend_vld;
        n_bw       = r_bw;
        n_start    = r_start;
        n_rej      = r_rej;
        n_stop     = r_stop;
        if (i_accept) begin
            if (i_unit.last_unit) begin
                n_pend_vld = 1'b0;
                n_bw       = '0;
                n_start    = 1'b1;
                n_rej      = 1'b0;
                n_stop     = 1'b0;
            end else begin
                n_start = 1'b0;
                n_rej   = rej;
                n_stop  = r_stop || stop1 || stop2;
                n_bw    = bw2;
                if (hold) begin
                    n_pend_vld = 1'b1;
                    n_pend_hi  = i_unit.code_unit;
                end else if (do1) begin
                    n_pend_vld = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_hi <= n_pend_hi;
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_bw       <= '0;
            r_start    <= 1'b1;
            r_rej      <= 1'b0;
            r_stop     <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            r_bw       <= n_bw;
            r_start    <= n_start;
            r_rej      <= n_rej;
            r_stop     <= n_stop;
        end
    end

    assign o_wr     = i_accept && (bundle.count != 3'd0);
    assign o_bundle = bundle;

endmodule

// File: rtl/u16u8_queue.sv
// Short bundle queue between the front end and the byte serializer.
// Depends on u16u8_pkg.
module u16u8_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  u16u8_pkg::t_bundle   i_bundle,
    input  logic                 i_rd,
    output logic                 o_full,
    output u16u8_pkg::t_q_head   o_head
);
    import u16u8_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count,  n_count;
    logic            do_wr, do_rd;

    always_comb begin
        do_wr    = i_wr && !o_full;
        do_rd    = i_rd && (r_count != '0);
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + Q_CW'(do_wr) - Q_CW'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_full        = (r_count == Q_CW'(Q_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.bundle = r_mem[r_rd_ptr];

endmodule

// File: rtl/u16u8_back.sv
// Back end: takes bundles from the queue and hands out one result per transaction.
// Depends on u16u8_pkg.
module u16u8_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  u16u8_pkg::t_q_head     i_head,
    output logic                   o_rd,
    input  logic                   i_pop,
    output logic                   o_empty,
    output u16u8_pkg::t_result_item o_result
);
    import u16u8_pkg::*;

    t_bundle    r_cur;
    logic       r_busy, n_busy;
    logic [2:0] r_idx,  n_idx;
    logic       taken, done_cur, load;

    always_comb begin
        taken    = i_pop && r_busy;
        done_cur = taken && (r_idx == r_cur.count - 3'd1);
        load     = i_head.valid && (!r_busy || done_cur);
        n_busy   = load ? 1'b1 : (done_cur ? 1'b0 : r_busy);
        if (load || done_cur) begin
            n_idx = '0;
        end else if (taken) begin
            n_idx = r_idx + 3'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_head.bundle;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    assign o_rd     = load;
    assign o_empty  = !r_busy;
    assign o_result = r_cur.items[r_idx];

endmodule

// File: sim/utf16_to_utf8_transcoder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf16_to_utf8_transcoder_unit: a directed stimulus table, then
// random strings under several register settings, checked against table entries or a behavioral predictor.
// Depends on u16u8_pkg and the transcoder RTL.
module utf16_to_utf8_transcoder_unit_tb;
    import u16u8_pkg::*;

    localparam int CAP_LIMIT     = 256;
    localparam int UNIT_LIMIT    = 63;
    localparam int RANDOM_UNITS  = 400;
    localparam int PHASE_UNITS   = 50;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PRINT_LIMIT   = 40;

    typedef enum {ROW_UNIT, ROW_CAPACITY, ROW_MAX_UNITS} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_unit_item  unit;
        logic [31:0] value;
        int          n_bytes;   // -1: expectation comes from the predictor
        logic [31:0] bytes;
        bit          term;
        logic [1:0]  st;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         push;
    logic         full;
    t_unit_item   i_unit;
    logic         pop;
    logic         empty;
    t_result_item o_result;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor state
    logic [8:0]   cap_reg;
    logic [5:0]   max_units_reg;
    logic [15:0]  held_high;
    bit           high_held;
    int           bytes_out;
    bit           string_fresh;
    bit           string_rejected;
    bit           output_full;

    t_result_item utf8_awaited[$];
    t_result_item unit_results[$];
    t_stim_row    stim_rows[$];

    bit steady;
    int cycles;
    int errors;
    int units_sent;
    int strings_sent;
    int results_seen;
    int terminators_seen;
    int reg_writes;

    utf16_to_utf8_transcoder_unit #(
        .MAX_UNITS_LIMIT(UNIT_LIMIT),
        .CAPACITY_LIMIT (CAP_LIMIT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_unit  (i_unit),
        .pop     (pop),
        .empty   (empty),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, utf8_awaited.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("MISMATCH @%0d: %s", cycles, msg);
    endtask

    function automatic void string_clear();
        held_high       = '0;
        high_held       = 1'b0;
        bytes_out       = 0;
        string_fresh    = 1'b1;
        string_rejected = 1'b0;
        output_full     = 1'b0;
    endfunction

    function automatic void emit_code_point(int unsigned cp);
        logic [7:0]  seq[$];
        int unsigned cap;
        int          nb;
        logic [7:0]  lead;
        if (output_full)
            return;
        cap = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
        if (cp < 'h80) begin
            seq.push_back((cp < 'h20 || cp == 'h7F) ? QMARK : 8'(cp));
        end else begin
            nb   = (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            lead = (nb == 2) ? 8'hC0 : (nb == 3) ? 8'hE0 : 8'hF0;
            seq.push_back(8'(lead | (cp >> (6 * (nb - 1)))));
            for (int k = nb - 2; k >= 0; k--)
                seq.push_back(8'(8'h80 | ((cp >> (6 * k)) & 'h3F)));
        end
        if (bytes_out + seq.size() >= cap) begin
            output_full = 1'b1;
            return;
        end
        foreach (seq[k])
            unit_results.push_back('{out_byte: seq[k], end_of_string: 1'b0, status: ST_OK});
        bytes_out += seq.size();
    endfunction

    function automatic void take_unit(logic [15:0] u, bit last);
        if (output_full)
            return;
        if (u >= HI_FIRST && u <= HI_LAST && !last) begin
            held_high = u;
            high_held = 1'b1;
        end else if (u >= LO_FIRST && u <= LO_LAST) begin
            emit_code_point(QMARK);
        end else begin
            emit_code_point(u);
        end
    endfunction

    // Results of one accepted unit land in unit_results.
    function automatic void transcode_unit(t_unit_item it);
        int unsigned hi_off;
        int unsigned lo_off;
        logic [1:0]  st;
        unit_results.delete();
        if (string_fresh) begin
            string_fresh    = 1'b0;
            string_rejected = (it.string_length == 0 || it.string_length > max_units_reg);
        end
        if (!string_rejected && !output_full) begin
            if (high_held) begin
                hi_off    = int'(held_high) - int'(HI_FIRST);
                high_held = 1'b0;
                held_high = '0;
                if (it.code_unit >= LO_FIRST && it.code_unit <= LO_LAST) begin
                    lo_off = int'(it.code_unit) - int'(LO_FIRST);
                    emit_code_point('h10000 + (hi_off << 10) + lo_off);
                end else begin
                    emit_code_point(QMARK);
                    take_unit(it.code_unit, it.last_unit);
                end
            end else begin
                take_unit(it.code_unit, it.last_unit);
            end
        end
        if (it.last_unit) begin
            st = string_rejected ? ST_REJECTED : (bytes_out == 0) ? ST_NO_BYTES : ST_OK;
            unit_results.push_back('{out_byte: 8'h00, end_of_string: 1'b1, status: st});
            string_clear();
        end
    endfunction

    task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_check(logic [0:0] idx, logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, {idx, 2'b00}, 32'h0, rd);
        if (rd !== want)
            report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h", idx, rd, want));
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {idx, 2'b00}, value, rd);
        if (idx == REG_OUT_CAPACITY) begin
            cap_reg = value[8:0];
            read_check(idx, {23'b0, value[8:0]});
        end else begin
            max_units_reg = value[5:0];
            read_check(idx, {26'b0, value[5:0]});
        end
        reg_writes++;
    endtask

    // Leaves push high after the transaction so back-to-back units need no extra edge.
    task automatic send_unit(t_unit_item it);
        while (!steady && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_unit <= it;
        do @(posedge i_clk); while (full);
        units_sent++;
        transcode_unit(it);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (utf8_awaited.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_string(bit long_run);
        logic [15:0] cus[$];
        logic [15:0] slen;
        int          len;
        int          pick;
        t_unit_item  it;
        if (long_run)
            len = $urandom_range(90, 110);
        else
            len = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        while (cus.size() < len) begin
            pick = long_run ? $urandom_range(53, 78) : $urandom_range(99);
            if (pick < 30) begin
                cus.push_back(16'($urandom_range('h20, 'h7E)));
            end else if (pick < 38) begin
                cus.push_back(($urandom_range(4) == 0) ? 16'h7F
                                                       : 16'($urandom_range(0, 'h1F)));
            end else if (pick < 52) begin
                cus.push_back(16'($urandom_range('h80, 'h7FF)));
            end else if (pick < 64) begin
                cus.push_back($urandom_range(1) ? 16'($urandom_range('h800, 'hD7FF))
                                                : 16'($urandom_range('hE000, 'hFFFF)));
            end else if (pick < 79) begin
                cus.push_back(16'($urandom_range(HI_FIRST, HI_LAST)));
                cus.push_back(16'($urandom_range(LO_FIRST, LO_LAST)));
            end else if (pick < 86) begin
                cus.push_back(16'($urandom_range(HI_FIRST, HI_LAST)));
            end else if (pick < 92) begin
                cus.push_back(16'($urandom_range(LO_FIRST, LO_LAST)));
            end else begin
                cus.push_back(16'($urandom()));
            end
        end
        pick = $urandom_range(99);
        if (long_run)
            slen = 16'($urandom_range(1, 20));
        else if (pick < 75)
            slen = 16'(cus.size());
        else if (pick < 83)
            slen = '0;
        else if (pick < 90)
            slen = 16'($urandom());
        else
            slen = 16'(cus.size() + $urandom_range(0, 4) - 2);
        foreach (cus[k]) begin
            it.code_unit     = cus[k];
            it.string_length = (k > 0 && $urandom_range(9) == 0) ? 16'($urandom()) : slen;
            it.last_unit     = (k == cus.size() - 1);
            send_unit(it);
            foreach (unit_results[j])
                utf8_awaited.push_back(unit_results[j]);
        end
        strings_sent++;
    endtask

    task automatic add_unit(logic [15:0] cu, logic [15:0] slen, bit last, int nb = -1,
                            logic [31:0] bytes = '0, bit term = 1'b0, logic [1:0] st = ST_OK);
        t_stim_row row;
        row.kind    = ROW_UNIT;
        row.unit    = '{code_unit: cu, string_length: slen, last_unit: last};
        row.value   = '0;
        row.n_bytes = nb;
        row.bytes   = bytes;
        row.term    = term;
        row.st      = st;
        stim_rows.push_back(row);
    endtask

    task automatic add_reg(t_row_kind kind, logic [31:0] value);
        t_stim_row row;
        row.kind    = kind;
        row.unit    = '0;
        row.value   = value;
        row.n_bytes = 0;
        row.bytes   = '0;
        row.term    = 1'b0;
        row.st      = ST_OK;
        stim_rows.push_back(row);
    endtask

    task automatic check_result(t_result_item got);
        t_result_item want;
        if (utf8_awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected result: byte 0x%02h eos %0d status %0d",
                                      got.out_byte, got.end_of_string, got.status));
            return;
        end
        want = utf8_awaited.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                      got.out_byte, want.out_byte));
        if (got.end_of_string !== want.end_of_string)
            report_mismatch($sformatf("end_of_string %0d, expected %0d",
                                      got.end_of_string, want.end_of_string));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        results_seen++;
        if (want.end_of_string)
            terminators_seen++;
    endtask

    initial begin : drain
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pop <= steady || ($urandom_range(99) >= 22);
            @(posedge i_clk);
            if (pop && !empty)
                check_result(o_result);
        end
    end

    initial begin : stimulus
        int phase;
        int drain_wait;
        logic [31:0] cap_pick;
        logic [31:0] units_pick;
        t_stim_row row;
        t_unit_item tail;

        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_unit  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        errors  = 0;
        steady  = 1'b0;
        strings_sent  = 0;
        cap_reg       = CAP_RESET;
        max_units_reg = UNITS_RESET;
        string_clear();

        // reset values, extremes of every field, each surrogate and control case
        add_unit(16'h0041, 16'd3, 1'b0, 1, 32'h41);
        add_unit(16'h0000, 16'd3, 1'b0, 1, 32'h3F);
        add_unit(16'h007F, 16'd3, 1'b0, 1, 32'h3F);
        add_unit(16'h00FF, 16'd3, 1'b0);
        add_unit(16'hFFFF, 16'd3, 1'b0);
        add_unit(16'hD800, 16'd3, 1'b0, 0);
        add_unit(16'hDC00, 16'd3, 1'b0);
        add_unit(16'hDBFF, 16'd3, 1'b0, 0);
        add_unit(16'hDFFF, 16'd3, 1'b0);
        add_unit(16'hD800, 16'd3, 1'b0, 0);
        add_unit(16'h0042, 16'd3, 1'b0, 2, 32'h3F42);
        add_unit(16'hDC00, 16'd3, 1'b0, 1, 32'h3F);
        add_unit(16'hDBFF, 16'd3, 1'b1);
        add_unit(16'h0041, 16'd0, 1'b1, 0, '0, 1'b1, ST_REJECTED);
        add_unit(16'h0041, 16'hFFFF, 1'b0, 0);
        add_unit(16'h0042, 16'd1, 1'b1, 0, '0, 1'b1, ST_REJECTED);
        add_reg(ROW_MAX_UNITS, 32'd63);
        add_unit(16'h0041, 16'd63, 1'b1, 1, 32'h41, 1'b1, ST_OK);
        add_reg(ROW_MAX_UNITS, 32'd0);
        add_unit(16'h0041, 16'd1, 1'b1, 0, '0, 1'b1, ST_REJECTED);
        add_reg(ROW_MAX_UNITS, 32'd31);
        add_reg(ROW_CAPACITY, 32'd0);
        add_unit(16'h0041, 16'd1, 1'b1, 0, '0, 1'b1, ST_NO_BYTES);
        add_reg(ROW_CAPACITY, 32'd2);
        add_unit(16'h0041, 16'd3, 1'b0, 1, 32'h41);
        add_unit(16'h0042, 16'd3, 1'b0, 0);
        add_unit(16'h0043, 16'd3, 1'b1, 0, '0, 1'b1, ST_OK);
        add_reg(ROW_CAPACITY, 32'd511);
        add_unit(16'h00E9, 16'd2, 1'b0);
        add_reg(ROW_CAPACITY, 32'd4);
        add_unit(16'h00E9, 16'd2, 1'b0, 0);
        add_unit(16'h0041, 16'd2, 1'b1, 0, '0, 1'b1, ST_OK);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_check(REG_OUT_CAPACITY, {23'b0, CAP_RESET});
        read_check(REG_MAX_UNITS, {26'b0, UNITS_RESET});

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            unique case (row.kind)
                ROW_CAPACITY: begin
                    wait_idle();
                    write_reg(REG_OUT_CAPACITY, row.value);
                end
                ROW_MAX_UNITS: begin
                    wait_idle();
                    write_reg(REG_MAX_UNITS, row.value);
                end
                default: begin
                    send_unit(row.unit);
                    if (row.unit.last_unit)
                        strings_sent++;
                    if (row.n_bytes < 0) begin
                        foreach (unit_results[j])
                            utf8_awaited.push_back(unit_results[j]);
                    end else begin
                        for (int k = 0; k < row.n_bytes; k++)
                            utf8_awaited.push_back('{
                                out_byte: 8'(row.bytes >> (8 * (row.n_bytes - 1 - k))),
                                end_of_string: 1'b0, status: ST_OK});
                        if (row.term)
                            utf8_awaited.push_back('{out_byte: 8'h00, end_of_string: 1'b1,
                                                     status: row.st});
                    end
                end
            endcase
        end
        if (string_fresh == 1'b0) begin
            tail = '{code_unit: 16'h0041, string_length: 16'd1, last_unit: 1'b1};
            send_unit(tail);
            foreach (unit_results[j])
                utf8_awaited.push_back(unit_results[j]);
            strings_sent++;
        end

        phase = 0;
        units_sent = 0;
        while (units_sent < RANDOM_UNITS) begin
            wait_idle();
            unique case (phase % 8)
                0: cap_pick = 32'd256;
                1: cap_pick = $urandom_range(2, 12);
                2: cap_pick = 32'd511;
                3: cap_pick = 32'd64;
                4: cap_pick = $urandom_range(0, 511);
                5: cap_pick = 32'd2;
                6: cap_pick = $urandom_range(13, 255);
                default: cap_pick = $urandom_range(0, 1);
            endcase
            unique case (phase % 4)
                0: units_pick = 32'd31;
                1: units_pick = $urandom_range(0, 63);
                2: units_pick = 32'd63;
                default: units_pick = $urandom_range(1, 20);
            endcase
            write_reg(REG_OUT_CAPACITY, cap_pick);
            write_reg(REG_MAX_UNITS, units_pick);
            steady = (phase == 3);
            if (phase == 2)
                send_random_string(1'b1);
            while (units_sent < PHASE_UNITS * (phase + 1))
                send_random_string(1'b0);
            steady = 1'b0;
            phase++;
        end

        push <= 1'b0;
        drain_wait = 0;
        while (utf8_awaited.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (utf8_awaited.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      utf8_awaited.size()));

        $display("Run covered %0d random code units, %0d strings in all, %0d settings, %0d writes",
                 units_sent, strings_sent, phase, reg_writes);
        $display("Checked %0d results, %0d of them terminators; %0d mismatches",
                 results_seen, terminators_seen, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder_unit.sv
sim/utf16_to_utf8_transcoder_unit_tb.sv
